// File: rtl/inverse_error_function_poly_assert.svh
// assertion macros used by the inverse error function top module
`ifndef INVERSE_ERROR_FUNCTION_POLY_ASSERT_SVH
`define INVERSE_ERROR_FUNCTION_POLY_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define ERFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define ERFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/erfp_pkg.sv
// types, constants and coefficient tables of the inverse error function pipeline
`timescale 1ns / 1ps

package erfp_pkg;

  typedef logic signed [31:0] x_t;
  typedef logic [32:0]        w_t;
  typedef logic [30:0]        root_t;
  typedef logic signed [34:0] coef_t;

  localparam int LOG_ROUNDS   = 28;
  localparam int SQRT_STEPS   = 31;
  localparam int HORNER_STEPS = 8;

  localparam x_t X_MIN       = 32'h8000_0000;
  localparam x_t X_NEG_CLAMP = 32'h8000_0001;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam w_t          W_SPLIT_Q28 = 33'd1342177280;
  localparam w_t          HALF5_Q28   = 33'd671088640;
  localparam w_t          THREE_Q28   = 33'd805306368;

  localparam coef_t CENTRAL_COEF [HORNER_STEPS+1] = '{
    35'sd30, 35'sd369, -35'sd3783, -35'sd4715, 35'sd234699, -35'sd1346177,
    -35'sd4485752, 35'sd264828464, 35'sd1612126078
  };

  localparam coef_t TAIL_COEF [HORNER_STEPS+1] = '{
    -35'sd214978, 35'sd108395, 35'sd1448846, -35'sd3944314, 35'sd6162749,
    -35'sd8184556, 35'sd10134910, 35'sd1075539332, 35'sd3041885698
  };

endpackage

// File: rtl/inverse_error_function_poly.sv
// Inverse error function x -> erfinv(x), Q1.31 in, Q4.28 out, fully pipelined.
// Input channel: in_valid, in_stall, arg_q131. A word is taken at a rising
// edge with in_valid high and in_stall low. Output channel: out_valid,
// out_stall, result_q428, taken the same way.
// An argument of exactly -1 is treated as -(1 - 2^-31).
// The pipeline includes the 28 log2 squaring stages, the 31 square-root
// stages and the 8 two-stage Horner steps. Throughput: one word per clock
// while in_stall is low.
// The whole pipeline moves on one enable. When the receiver stalls, the
// output register holds its word and one further word lands in a skid
// register; only then is in_stall raised, and the pipeline freezes without
// losing or repeating anything. in_stall falls when the skid empties.
// Reset (rst, synchronous) clears all valid bits, among them those of the
// output and the skid; no table or memory needs clearing.
`timescale 1ns / 1ps

`include "inverse_error_function_poly_assert.svh"

module inverse_error_function_poly import erfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  x_t   arg_q131,
  output logic out_valid,
  input  logic out_stall,
  output x_t   result_q428
);

  logic  en;
  logic  skid_v;
  x_t    skid_result;
  logic  lg_v;
  x_t    lg_x;
  w_t    lg_w;
  logic  sq_v;
  x_t    sq_x;
  w_t    sq_w;
  root_t sq_s;
  logic  pipe_v;
  x_t    pipe_result;
  logic  out_take;

  // pipeline advances while the skid is empty
  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign out_take = out_valid && !out_stall;

  erfp_log u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_x      (arg_q131),
    .out_valid (lg_v),
    .out_x     (lg_x),
    .out_w     (lg_w)
  );

  erfp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lg_v),
    .in_x      (lg_x),
    .in_w      (lg_w),
    .out_valid (sq_v),
    .out_x     (sq_x),
    .out_w     (sq_w),
    .out_s     (sq_s)
  );

  erfp_horner u_horner (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sq_v),
    .in_x       (sq_x),
    .in_w       (sq_w),
    .in_s       (sq_s),
    .out_valid  (pipe_v),
    .out_result (pipe_result)
  );

  // output register and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_take) begin
        result_q428 <= skid_result;
        skid_v      <= 1'b0;
      end
    end else if (pipe_v) begin
      if (!out_valid || out_take) begin
        result_q428 <= pipe_result;
        out_valid   <= 1'b1;
      end else begin
        skid_result <= pipe_result;
        skid_v      <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  `ERFP_ASSERT_IMP(a_skid_needs_out, skid_v, out_valid, "skid word without output word")
  `ERFP_ASSERT_NXT(a_skid_holds, skid_v && out_stall, skid_v, "skid word lost under stall")
  `ERFP_ASSERT_NXT(a_pipe_frozen, skid_v, $stable(pipe_v) && $stable(pipe_result), "pipe moved while full")
  `ERFP_ASSERT_NXT(a_skid_fills, out_valid && out_stall && !skid_v && pipe_v, skid_v, "word dropped at stall")

endmodule

// File: rtl/erfp_log.sv
// front pipeline: clamp, 1-x^2, normalize, bitwise log2 and scaling to w = -ln(1-x^2)
`timescale 1ns / 1ps

module erfp_log import erfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  x_t   in_x,
  output logic out_valid,
  output x_t   out_x,
  output w_t   out_w
);

  // clamp minus one and take the magnitude
  x_t          xc;
  logic        v1;
  x_t          x1;
  logic [30:0] a1;

  always_comb begin
    xc = (in_x == X_MIN) ? X_NEG_CLAMP : in_x;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      x1 <= xc;
      a1 <= xc[31] ? 31'(-xc) : xc[30:0];
    end
  end

  // t = 1 - x^2 in q0.62
  logic        v2;
  x_t          x2;
  logic [62:0] t2;
  logic [61:0] sq2;

  assign sq2 = a1 * a1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x2 <= x1;
      t2 <= {1'b1, 62'b0} - {1'b0, sq2};
    end
  end

  // leading one, first pass: per-byte flags and positions
  logic [63:0] t64;
  logic [7:0]  nz_c;
  logic [2:0]  pos_c [8];
  logic        v3;
  x_t          x3;
  logic [62:0] t3;
  logic [7:0]  nz3;
  logic [2:0]  pos3 [8];

  assign t64 = {1'b0, t2};

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_c[g]  = |t64[8*g +: 8];
      pos_c[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (t64[8*g + b]) pos_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      x3   <= x2;
      t3   <= t2;
      nz3  <= nz_c;
      pos3 <= pos_c;
    end
  end

  // leading one, second pass: highest nonzero byte
  logic [5:0]  e_c;
  logic        v4;
  x_t          x4;
  logic [62:0] t4;
  logic [5:0]  e4;

  always_comb begin
    e_c = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (nz3[g]) e_c = {3'(g), pos3[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      x4 <= x3;
      t4 <= t3;
      e4 <= e_c;
    end
  end

  // normalize to a q1.31 mantissa in [1,2)
  logic [5:0]  sh_c;
  logic [62:0] tn_c;
  logic        v5;
  x_t          x5;
  logic [4:0]  k5;
  logic [31:0] m5;

  assign sh_c = 6'd62 - e4;
  assign tn_c = t4 << sh_c;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      x5 <= x4;
      k5 <= sh_c[4:0];
      m5 <= tn_c[62:31];
    end
  end

  // one fraction bit per stage by squaring the mantissa
  logic                  vr [LOG_ROUNDS+1];
  x_t                    xr [LOG_ROUNDS+1];
  logic [4:0]            kr [LOG_ROUNDS+1];
  logic [31:0]           mr [LOG_ROUNDS+1];
  logic [LOG_ROUNDS-1:0] fr [LOG_ROUNDS+1];

  assign vr[0] = v5;
  assign xr[0] = x5;
  assign kr[0] = k5;
  assign mr[0] = m5;
  assign fr[0] = '0;

  for (genvar r = 0; r < LOG_ROUNDS; r++) begin : g_round
    logic [63:0] prod;
    logic [32:0] msq;

    assign prod = mr[r] * mr[r];
    assign msq  = prod[63:31];

    always_ff @(posedge clk) begin
      if (rst) vr[r+1] <= 1'b0;
      else if (en) vr[r+1] <= vr[r];
      if (en) begin
        xr[r+1] <= xr[r];
        kr[r+1] <= kr[r];
        mr[r+1] <= msq[32] ? msq[32:1] : msq[31:0];
        fr[r+1] <= {fr[r][LOG_ROUNDS-2:0], msq[32]};
      end
    end
  end

  // -log2(1-x^2) in q.28
  logic        vl;
  x_t          xl;
  logic [32:0] lg;

  always_ff @(posedge clk) begin
    if (rst) vl <= 1'b0;
    else if (en) vl <= vr[LOG_ROUNDS];
    if (en) begin
      xl <= xr[LOG_ROUNDS];
      lg <= {kr[LOG_ROUNDS], 28'b0} - {5'b0, fr[LOG_ROUNDS]};
    end
  end

  // scale by ln2
  logic        vm;
  x_t          xm;
  logic [62:0] wp;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= vl;
    if (en) begin
      xm <= xl;
      wp <= lg * LN2_Q30;
    end
  end

  // round to q.28
  logic [63:0] wr_c;

  assign wr_c = {1'b0, wp} + 64'd536870912;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vm;
    if (en) begin
      out_x <= xm;
      out_w <= wr_c[62:30];
    end
  end

endmodule

// File: rtl/erfp_sqrt.sv
// square root pipeline, one root bit per stage, w and x ride along
`timescale 1ns / 1ps

module erfp_sqrt import erfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  x_t    in_x,
  input  w_t    in_w,
  output logic  out_valid,
  output x_t    out_x,
  output w_t    out_w,
  output root_t out_s
);

  logic        vs   [SQRT_STEPS+1];
  x_t          xs   [SQRT_STEPS+1];
  w_t          ws   [SQRT_STEPS+1];
  logic [61:0] rem  [SQRT_STEPS+1];
  logic [61:0] root [SQRT_STEPS+1];

  // radicand is w in q.56
  assign vs[0]   = in_valid;
  assign xs[0]   = in_x;
  assign ws[0]   = in_w;
  assign rem[0]  = {1'b0, in_w, 28'b0};
  assign root[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [61:0] trial;
    logic        fits;

    assign trial = root[i] + BIT;
    assign fits  = rem[i] >= trial;

    // restoring step
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else if (en) vs[i+1] <= vs[i];
      if (en) begin
        xs[i+1]   <= xs[i];
        ws[i+1]   <= ws[i];
        rem[i+1]  <= fits ? rem[i] - trial : rem[i];
        root[i+1] <= fits ? (root[i] >> 1) + BIT : root[i] >> 1;
      end
    end
  end

  assign out_valid = vs[SQRT_STEPS];
  assign out_x     = xs[SQRT_STEPS];
  assign out_w     = ws[SQRT_STEPS];
  assign out_s     = root[SQRT_STEPS][30:0];

endmodule

// File: rtl/erfp_horner.sv
// branch select, horner polynomial stages and the final multiply by x
`timescale 1ns / 1ps

module erfp_horner import erfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  x_t    in_x,
  input  w_t    in_w,
  input  root_t in_s,
  output logic  out_valid,
  output x_t    out_result
);

  // pick branch and form d in q.28
  logic        tail_c;
  logic [33:0] dc_c;
  logic [32:0] dt_c;

  assign tail_c = in_w >= W_SPLIT_Q28;
  assign dc_c   = {1'b0, in_w} - {1'b0, HALF5_Q28};
  assign dt_c   = {2'b0, in_s} - THREE_Q28;

  logic               vh   [HORNER_STEPS+1];
  x_t                 xh   [HORNER_STEPS+1];
  logic               th   [HORNER_STEPS+1];
  logic signed [31:0] dh   [HORNER_STEPS+1];
  coef_t              ph   [HORNER_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) vh[0] <= 1'b0;
    else if (en) vh[0] <= in_valid;
    if (en) begin
      xh[0] <= in_x;
      th[0] <= tail_c;
      dh[0] <= tail_c ? dt_c[31:0] : dc_c[31:0];
      ph[0] <= tail_c ? TAIL_COEF[0] : CENTRAL_COEF[0];
    end
  end

  // each step: multiply stage, then round and add stage
  for (genvar i = 1; i <= HORNER_STEPS; i++) begin : g_horner
    logic               vp;
    x_t                 xp;
    logic               tp;
    logic signed [31:0] dp;
    logic signed [66:0] prod;
    logic signed [66:0] rnd;

    always_ff @(posedge clk) begin
      if (rst) vp <= 1'b0;
      else if (en) vp <= vh[i-1];
      if (en) begin
        xp   <= xh[i-1];
        tp   <= th[i-1];
        dp   <= dh[i-1];
        prod <= ph[i-1] * dh[i-1];
      end
    end

    assign rnd = (prod + 67'sd134217728) >>> 28;

    always_ff @(posedge clk) begin
      if (rst) vh[i] <= 1'b0;
      else if (en) vh[i] <= vp;
      if (en) begin
        xh[i] <= xp;
        th[i] <= tp;
        dh[i] <= dp;
        ph[i] <= (tp ? TAIL_COEF[i] : CENTRAL_COEF[i]) + 35'(rnd);
      end
    end
  end

  // p to q.28 and multiply by x
  coef_t              pr_c;
  logic signed [32:0] p28_c;
  logic               vf;
  logic signed [64:0] fprod;

  assign pr_c  = (ph[HORNER_STEPS] + 35'sd2) >>> 2;
  assign p28_c = 33'(pr_c);

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= vh[HORNER_STEPS];
    if (en) fprod <= p28_c * xh[HORNER_STEPS];
  end

  // round to q4.28 and saturate
  logic signed [64:0] fr_c;
  logic signed [33:0] r_c;
  x_t                 sat_c;

  assign fr_c = (fprod + 65'sd1073741824) >>> 31;
  assign r_c  = 34'(fr_c);

  always_comb begin
    if (r_c > 34'sd2147483647) sat_c = 32'h7FFF_FFFF;
    else if (r_c < -34'sd2147483648) sat_c = 32'h8000_0000;
    else sat_c = r_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vf;
    if (en) out_result <= sat_c;
  end

endmodule
